// ===== src/gra_pkg.sv =====
// Package with the command and result item types of the grid rectangle allocator.
`default_nettype none
package gra_pkg;
    localparam logic [1:0] FUNC_PLACE  = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;
    localparam int unsigned PLACE_MAX_W = 2;
    localparam int unsigned PLACE_MAX_H = 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] item_id;
        logic [3:0]  pos_x;
        logic [2:0]  pos_y;
        logic [2:0]  size_x;
        logic [2:0]  size_y;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] found_x;
        logic [2:0] found_y;
    } res_t;
endpackage
`default_nettype wire

// ===== src/grid_rectangle_allocator.sv =====
// Top level of the grid rectangle allocator: command sequencer around one grid memory.
`default_nettype none
// Usage
// A command item is taken at a rising edge where start is high and busy is low.
// Exactly one result item follows per command, shown on res for one cycle while
// done is high; the receiver cannot stall it, so it must sample on that edge.
// busy is high from the accepting edge until the result has been shown.
// The grid lives in one synchronous memory of 32-bit cells with a registered read,
// addressed by {row, column}; DEPTH is GRID_X*GRID_Y for power-of-two
// sizes. A clearing pass reads each cell and writes zero to each one that
// holds the owner being cleared. Steps per command, accept to accept:
//   Rejected commands: no memory access; the result follows directly.
//   Remove: one clearing pass, then the result.
//   Place: the rectangle holds at most 8 cells; each is read and,
//   when it holds an owner, a clearing pass for that owner runs and the cell is
//   read again; then every cell of the rectangle is written.
//   Find: each candidate origin reads up to w*h cells (at most 49).
// After reset the block sweeps every cell to zero with busy held high;
// no command is accepted during that sweep.
module grid_rectangle_allocator #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire gra_pkg::cmd_t  cmd,
    output logic                busy,
    output logic                done,
    output gra_pkg::res_t       res
);
    import gra_pkg::*;

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLR_RD = 4'd2;
    localparam logic [3:0] S_CLR_WT = 4'd3;
    localparam logic [3:0] S_PL_RD  = 4'd4;
    localparam logic [3:0] S_PL_WT  = 4'd5;
    localparam logic [3:0] S_PL_WR  = 4'd6;
    localparam logic [3:0] S_FD_RD  = 4'd7;
    localparam logic [3:0] S_FD_WT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;
    logic        re, we;
    logic [AW-1:0] raddr, waddr;
    logic [31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    logic [3:0]  state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    res_t        res_reg, res_next;
    logic [31:0] clr_id_reg, clr_id_next;
    // Sweep address of clearing passes.
    logic [AW:0] sweep_reg, sweep_next;
    // Cell offset inside the rectangle (place and find).
    logic [2:0]  dx_reg, dx_next, dy_reg, dy_next;
    // Find origin.
    logic [6:0]  ox_reg, ox_next, oy_reg, oy_next;
    // True while a place pass clears an owner, so it returns to the place walk.
    logic        from_pl_reg, from_pl_next;

    logic [6:0] cx, cy;
    logic [6:0] ext_x, ext_y;
    logic       place_bad, last_cell;

    always_comb
    begin
        cx = 7'(cmd_reg.pos_x) + 7'(dx_reg);
        cy = 7'(cmd_reg.pos_y) + 7'(dy_reg);
        if (cmd_reg.func == FUNC_FIND)
        begin
            cx = ox_reg + 7'(dx_reg);
            cy = oy_reg + 7'(dy_reg);
        end
        ext_x = 7'(cmd.pos_x) + 7'(cmd.size_x);
        ext_y = 7'(cmd.pos_y) + 7'(cmd.size_y);
        place_bad = (cmd.item_id == '0) || (cmd.size_x == '0)
            || (32'(cmd.size_x) > PLACE_MAX_W) || (cmd.size_y == '0)
            || (32'(cmd.size_y) > PLACE_MAX_H)
            || (32'(ext_x) > GRID_X) || (32'(ext_y) > GRID_Y);
        last_cell = (dx_reg == cmd_reg.size_x - 3'd1)
            && (dy_reg == cmd_reg.size_y - 3'd1);
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        clr_id_next  = clr_id_reg;
        sweep_next   = sweep_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        from_pl_next = from_pl_reg;
        re    = 1'b0;
        we    = 1'b0;
        raddr = {cy[YW-1:0], cx[XW-1:0]};
        waddr = sweep_reg[AW-1:0];
        wdata = '0;
        case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (32'(sweep_reg) == DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    dx_next = '0;
                    dy_next = '0;
                    ox_next = '0;
                    oy_next = '0;
                    sweep_next = '0;
                    state_next = S_DONE;
                    case (cmd.func)
                        FUNC_PLACE:
                        begin
                            if (!place_bad)
                            begin
                                res_next.ok = 1'b1;
                                state_next = S_PL_RD;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (cmd.item_id != '0)
                            begin
                                res_next.ok = 1'b1;
                                clr_id_next = cmd.item_id;
                                from_pl_next = 1'b0;
                                state_next = S_CLR_RD;
                            end
                        end
                        FUNC_FIND:
                        begin
                            if (cmd.size_x != '0 && cmd.size_y != '0)
                            begin
                                state_next = S_FD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR_RD:
            begin
                re = 1'b1;
                raddr = sweep_reg[AW-1:0];
                state_next = S_CLR_WT;
            end
            S_CLR_WT:
            begin
                // Read data for the cell at sweep_reg is now valid.
                if (rdata_reg == clr_id_reg)
                begin
                    we = 1'b1;
                end
                sweep_next = sweep_reg + 1'b1;
                state_next = S_CLR_RD;
                if (32'(sweep_reg) == DEPTH - 1)
                begin
                    sweep_next = '0;
                    state_next = from_pl_reg ? S_PL_RD : S_DONE;
                end
            end
            S_PL_RD:
            begin
                re = 1'b1;
                state_next = S_PL_WT;
            end
            S_PL_WT:
            begin
                if (rdata_reg != '0)
                begin
                    clr_id_next = rdata_reg;
                    from_pl_next = 1'b1;
                    sweep_next = '0;
                    state_next = S_CLR_RD;
                end
                else if (last_cell)
                begin
                    dx_next = '0;
                    dy_next = '0;
                    state_next = S_PL_WR;
                end
                else
                begin
                    state_next = S_PL_RD;
                    if (dx_reg == cmd_reg.size_x - 3'd1)
                    begin
                        dx_next = '0;
                        dy_next = dy_reg + 3'd1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 3'd1;
                    end
                end
            end
            S_PL_WR:
            begin
                we = 1'b1;
                waddr = {cy[YW-1:0], cx[XW-1:0]};
                wdata = cmd_reg.item_id;
                if (last_cell)
                begin
                    state_next = S_DONE;
                end
                else if (dx_reg == cmd_reg.size_x - 3'd1)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 3'd1;
                end
                else
                begin
                    dx_next = dx_reg + 3'd1;
                end
            end
            S_FD_RD:
            begin
                if (32'(oy_reg) + 32'(cmd_reg.size_y) > GRID_Y)
                begin
                    state_next = S_DONE;
                end
                else if (32'(ox_reg) + 32'(cmd_reg.size_x) > GRID_X)
                begin
                    ox_next = '0;
                    oy_next = oy_reg + 7'd1;
                end
                else
                begin
                    re = 1'b1;
                    state_next = S_FD_WT;
                end
            end
            S_FD_WT:
            begin
                state_next = S_FD_RD;
                if (rdata_reg != '0)
                begin
                    dx_next = '0;
                    dy_next = '0;
                    ox_next = ox_reg + 7'd1;
                end
                else if (last_cell)
                begin
                    res_next.ok = 1'b1;
                    res_next.found_x = 4'(ox_reg);
                    res_next.found_y = 3'(oy_reg);
                    state_next = S_DONE;
                end
                else if (dx_reg == cmd_reg.size_x - 3'd1)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 3'd1;
                end
                else
                begin
                    dx_next = dx_reg + 3'd1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            sweep_reg   <= '0;
            from_pl_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            from_pl_reg <= from_pl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        clr_id_reg <= clr_id_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;

    // A failed command never reports a position.
    a_no_pos_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res.ok |-> res.found_x == '0 && res.found_y == '0)
        else $error("position reported on a failed command");
    // The memory is never written while idle.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !we)
        else $error("grid written while idle");
    // A result is shown for one cycle only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire
